// ===== design/lptte_pkg.sv =====
package lptte_pkg;

    // Width of the signed value that a number field must fit in.
    localparam int VALUE_BITS = 64;
    localparam int MAG_W      = VALUE_BITS - 1;
    // The magnitude times ten plus a digit stays below 2^(VALUE_BITS+3).
    localparam int PROD_W     = VALUE_BITS + 3;
    localparam logic [MAG_W-1:0] MAG_LIMIT = '1;

    localparam int POS_W      = 4;
    localparam int PREFIX_LEN = 15;
    localparam int ITEM_LEN   = 12;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_CLOSE  = 8'h5d;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_ITEM   = 3'd1,
        PH_QUOTE  = 3'd2,
        PH_NUMBER = 3'd3,
        PH_CLOSE  = 3'd4,
        PH_FAULT  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        FK_NONE   = 3'd0,
        FK_PREFIX = 3'd1,
        FK_ITEM   = 3'd2,
        FK_QUOTE  = 3'd3,
        FK_NUMBER = 3'd4,
        FK_END    = 3'd5
    } fault_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } path_item_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       done_res;
        logic       ok;
        fault_t     fault_kind;
    } tag_result_t;

    // Characters of "/document/label".
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "/";
            4'd1:    ch = "d";
            4'd2:    ch = "o";
            4'd3:    ch = "c";
            4'd4:    ch = "u";
            4'd5:    ch = "m";
            4'd6:    ch = "e";
            4'd7:    ch = "n";
            4'd8:    ch = "t";
            4'd9:    ch = "/";
            4'd10:   ch = "l";
            4'd11:   ch = "a";
            4'd12:   ch = "b";
            4'd13:   ch = "e";
            4'd14:   ch = "l";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "/label[@tag=".
    function automatic logic [7:0] item_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "/";
            4'd1:    ch = "l";
            4'd2:    ch = "a";
            4'd3:    ch = "b";
            4'd4:    ch = "e";
            4'd5:    ch = "l";
            4'd6:    ch = "[";
            4'd7:    ch = "@";
            4'd8:    ch = "t";
            4'd9:    ch = "a";
            4'd10:   ch = "g";
            4'd11:   ch = "=";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/label_path_to_tag_entry.sv =====
// Converts a label reference path, one character per transfer, into tag entry text.
// Every input character gives exactly one result: the character to emit, if any, plus
// done and ok on the character marked last. Throughput is one character per cycle while
// result_stall is low; each character passes through the input register and then the result
// register, with the full per-character parse step, including the 63-bit times-ten accumulate
// and its overflow compare, done between them. Results must be discarded when ok is 0.
module label_path_to_tag_entry
    import lptte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  path_item_t  item,
    output logic        result_valid,
    input  logic        result_stall,
    output tag_result_t result
);

    logic              in_vld_reg;
    path_item_t        in_reg;
    logic              out_vld_reg;
    tag_result_t       out_reg;
    logic              advance;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              dquote_reg, dquote_next;
    logic              minus_reg, minus_next;
    logic              sign_reg, sign_next;
    logic              digit_reg, digit_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              ovf_reg, ovf_next;
    fault_t            fault_reg, fault_next;

    tag_result_t       res;
    logic [7:0]        c;
    logic [PROD_W-1:0] mag_ext;
    logic [PROD_W-1:0] prod;
    logic              close_match;

    // The input register moves on whenever the result register is free or draining.
    assign advance      = in_vld_reg && (!out_vld_reg || !result_stall);
    assign item_stall   = in_vld_reg && !advance;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    assign c           = in_reg.in_char;
    assign mag_ext     = PROD_W'(mag_reg);
    assign prod        = (mag_ext << 3) + (mag_ext << 1) + PROD_W'(c[3:0]);
    assign close_match = (c == (dquote_reg ? CH_DQUOTE : CH_SQUOTE));

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        dquote_next = dquote_reg;
        minus_next  = minus_reg;
        sign_next   = sign_reg;
        digit_next  = digit_reg;
        mag_next    = mag_reg;
        ovf_next    = ovf_reg;
        fault_next  = fault_reg;
        res         = '0;
        res.fault_kind = FK_NONE;

        case (phase_reg)
            PH_PREFIX:
            begin
                if (c == prefix_char(pos_reg))
                begin
                    if (pos_reg == POS_W'(PREFIX_LEN - 1))
                    begin
                        res.char_valid = 1'b1;
                        res.out_char   = CH_ZERO;
                        phase_next     = PH_ITEM;
                        pos_next       = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else
                begin
                    fault_next = FK_PREFIX;
                    phase_next = PH_FAULT;
                end
            end
            PH_ITEM:
            begin
                if (c == item_char(pos_reg))
                begin
                    if (pos_reg == POS_W'(ITEM_LEN - 1))
                    begin
                        phase_next = PH_QUOTE;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else
                begin
                    fault_next = FK_ITEM;
                    phase_next = PH_FAULT;
                end
            end
            PH_QUOTE:
            begin
                if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    dquote_next    = (c == CH_DQUOTE);
                    minus_next     = 1'b0;
                    sign_next      = 1'b0;
                    digit_next     = 1'b0;
                    mag_next       = '0;
                    ovf_next       = 1'b0;
                    res.char_valid = 1'b1;
                    res.out_char   = CH_COLON;
                    phase_next     = PH_NUMBER;
                end
                else
                begin
                    fault_next = FK_QUOTE;
                    phase_next = PH_FAULT;
                end
            end
            PH_NUMBER:
            begin
                if (c inside {[CH_ZERO:CH_NINE]})
                begin
                    // Saturate when ten times the magnitude plus the digit passes the limit.
                    if (prod > PROD_W'(MAG_LIMIT))
                    begin
                        mag_next = MAG_LIMIT;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = prod[MAG_W-1:0];
                    end
                    digit_next     = 1'b1;
                    res.char_valid = 1'b1;
                    res.out_char   = c;
                end
                else if ((c == CH_PLUS || c == CH_MINUS) && !sign_reg && !digit_reg)
                begin
                    sign_next      = 1'b1;
                    minus_next     = (c == CH_MINUS);
                    res.char_valid = 1'b1;
                    res.out_char   = c;
                end
                else if ((c inside {[CH_TAB:CH_CR], CH_SPACE}) && !sign_reg && !digit_reg)
                begin
                    res.char_valid = 1'b1;
                    res.out_char   = c;
                end
                else if (close_match)
                begin
                    if (!digit_reg || ovf_reg || (minus_reg && mag_reg != '0))
                    begin
                        fault_next = FK_NUMBER;
                        phase_next = PH_FAULT;
                    end
                    else
                    begin
                        phase_next = PH_CLOSE;
                    end
                end
                else
                begin
                    fault_next = FK_NUMBER;
                    phase_next = PH_FAULT;
                end
            end
            PH_CLOSE:
            begin
                if (c == CH_CLOSE)
                begin
                    phase_next = PH_ITEM;
                    pos_next   = '0;
                end
                else
                begin
                    fault_next = FK_END;
                    phase_next = PH_FAULT;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        res.fault_kind = fault_next;
        if (in_reg.is_last)
        begin
            res.done_res = 1'b1;
            if (fault_next == FK_NONE)
            begin
                // A path may only end right after the prefix or after a closing bracket.
                if (phase_next == PH_ITEM && pos_next == '0)
                    res.ok = 1'b1;
                else if (phase_next == PH_PREFIX)
                    res.fault_kind = FK_PREFIX;
                else
                    res.fault_kind = FK_END;
            end
            phase_next  = PH_PREFIX;
            pos_next    = '0;
            dquote_next = 1'b0;
            minus_next  = 1'b0;
            sign_next   = 1'b0;
            digit_next  = 1'b0;
            mag_next    = '0;
            ovf_next    = 1'b0;
            fault_next  = FK_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_PREFIX;
            pos_reg     <= '0;
            dquote_reg  <= 1'b0;
            minus_reg   <= 1'b0;
            sign_reg    <= 1'b0;
            digit_reg   <= 1'b0;
            mag_reg     <= '0;
            ovf_reg     <= 1'b0;
            fault_reg   <= FK_NONE;
        end
        else
        begin
            if (!item_stall)
                in_vld_reg <= item_valid;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (!result_stall)
                out_vld_reg <= 1'b0;

            if (advance)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                dquote_reg <= dquote_next;
                minus_reg  <= minus_next;
                sign_reg   <= sign_next;
                digit_reg  <= digit_next;
                mag_reg    <= mag_next;
                ovf_reg    <= ovf_next;
                fault_reg  <= fault_next;
            end
        end
    end

    // Payload registers load on a transfer and need no reset.
    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            in_reg <= item;
        if (advance)
            out_reg <= res;
    end

endmodule

// ===== test/tag_entry_checker.sv =====
`timescale 1ns / 1ps

module tag_entry_checker
    import lptte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  path_item_t  item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  tag_result_t result,
    output int          mismatches,
    output int          pending,
    output int          paths_ok,
    output int          paths_failed
);

    localparam logic [8*PREFIX_LEN-1:0] DOC_TEXT  = "/document/label";
    localparam logic [8*ITEM_LEN-1:0]   STEP_TEXT = "/label[@tag=";
    localparam logic [VALUE_BITS-1:0]   MAG_TOP   = {1'b0, MAG_LIMIT};

    phase_t                ph;
    logic [POS_W-1:0]      pos;
    logic                  dq;
    logic                  neg;
    logic                  sign_seen;
    logic                  digit_seen;
    logic [VALUE_BITS-1:0] mag;
    logic                  ovf;
    fault_t                flt;

    tag_result_t expected_tags[$];
    int          results_seen;

    function automatic logic [7:0] text_byte(input logic [8*PREFIX_LEN-1:0] text,
                                             input int len, input int at);
        return text[8*(len-1-at) +: 8];
    endfunction

    function automatic void clear_path();
        ph         = PH_PREFIX;
        pos        = '0;
        dq         = 1'b0;
        neg        = 1'b0;
        sign_seen  = 1'b0;
        digit_seen = 1'b0;
        mag        = '0;
        ovf        = 1'b0;
        flt        = FK_NONE;
    endfunction

    function automatic void raise(input fault_t kind);
        flt = kind;
        ph  = PH_FAULT;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Advances the parse by one path character and returns the tag entry result it gives.
    function automatic tag_result_t next_tag_char(input path_item_t it);
        tag_result_t           r;
        logic [7:0]            c;
        logic [VALUE_BITS-1:0] d;
        r = '0;
        c = it.in_char;
        d = '0;
        case (ph)
            PH_PREFIX:
                if (c == text_byte(DOC_TEXT, PREFIX_LEN, pos))
                begin
                    pos = pos + 1'b1;
                    if (pos == PREFIX_LEN)
                    begin
                        r.char_valid = 1'b1;
                        r.out_char   = CH_ZERO;
                        ph           = PH_ITEM;
                        pos          = '0;
                    end
                end
                else
                begin
                    raise(FK_PREFIX);
                end
            PH_ITEM:
                if (c == text_byte(STEP_TEXT, ITEM_LEN, pos))
                begin
                    pos = pos + 1'b1;
                    if (pos == ITEM_LEN)
                    begin
                        ph  = PH_QUOTE;
                        pos = '0;
                    end
                end
                else
                begin
                    raise(FK_ITEM);
                end
            PH_QUOTE:
                if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    dq           = (c == CH_DQUOTE);
                    neg          = 1'b0;
                    sign_seen    = 1'b0;
                    digit_seen   = 1'b0;
                    mag          = '0;
                    ovf          = 1'b0;
                    r.char_valid = 1'b1;
                    r.out_char   = CH_COLON;
                    ph           = PH_NUMBER;
                end
                else
                begin
                    raise(FK_QUOTE);
                end
            PH_NUMBER:
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    d[7:0] = c - CH_ZERO;
                    // Saturate instead of wrapping once the value cannot fit.
                    if (mag > (MAG_TOP - d) / 10)
                    begin
                        mag = MAG_TOP;
                        ovf = 1'b1;
                    end
                    else
                    begin
                        mag = mag * 10 + d;
                    end
                    digit_seen   = 1'b1;
                    r.char_valid = 1'b1;
                    r.out_char   = c;
                end
                else if ((c == CH_PLUS || c == CH_MINUS) && !sign_seen && !digit_seen)
                begin
                    sign_seen    = 1'b1;
                    neg          = (c == CH_MINUS);
                    r.char_valid = 1'b1;
                    r.out_char   = c;
                end
                else if (is_white(c) && !sign_seen && !digit_seen)
                begin
                    r.char_valid = 1'b1;
                    r.out_char   = c;
                end
                else if (c == (dq ? CH_DQUOTE : CH_SQUOTE))
                begin
                    if (!digit_seen || ovf || (neg && mag != 0))
                        raise(FK_NUMBER);
                    else
                        ph = PH_CLOSE;
                end
                else
                begin
                    raise(FK_NUMBER);
                end
            PH_CLOSE:
                if (c == CH_CLOSE)
                begin
                    ph  = PH_ITEM;
                    pos = '0;
                end
                else
                begin
                    raise(FK_END);
                end
            default:
                ;
        endcase

        r.fault_kind = flt;
        if (it.is_last)
        begin
            r.done_res = 1'b1;
            if (flt == FK_NONE)
            begin
                if (ph == PH_ITEM && pos == 0)
                    r.ok = 1'b1;
                else if (ph == PH_PREFIX)
                    r.fault_kind = FK_PREFIX;
                else
                    r.fault_kind = FK_END;
            end
            clear_path();
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tag_result_t want;
        if (!rst_n)
        begin
            clear_path();
            expected_tags.delete();
            mismatches   = 0;
            pending      = 0;
            paths_ok     = 0;
            paths_failed = 0;
            results_seen = 0;
        end
        else
        begin
            // A result transfer can never belong to an item accepted at the same edge.
            if (result_valid && !result_stall)
            begin
                if (expected_tags.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %0d: valid=%b char=%02h done=%b ok=%b fault=%0d",
                                 results_seen, result.char_valid, result.out_char,
                                 result.done_res, result.ok, result.fault_kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    if (result.char_valid !== want.char_valid || result.out_char !== want.out_char
                        || result.done_res !== want.done_res || result.ok !== want.ok
                        || result.fault_kind !== want.fault_kind)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("mismatch on result %0d: expected valid=%b char=%02h done=%b ok=%b fault=%0d",
                                     results_seen, want.char_valid, want.out_char,
                                     want.done_res, want.ok, want.fault_kind);
                            $display("    got valid=%b char=%02h done=%b ok=%b fault=%0d",
                                     result.char_valid, result.out_char, result.done_res,
                                     result.ok, result.fault_kind);
                        end
                        mismatches++;
                    end
                end
                results_seen++;
            end
            if (item_valid && !item_stall)
            begin
                want = next_tag_char(item);
                expected_tags.push_back(want);
                if (want.done_res)
                begin
                    if (want.ok)
                        paths_ok++;
                    else
                        paths_failed++;
                end
            end
            pending = expected_tags.size();
        end
    end

endmodule

// ===== test/label_path_to_tag_entry_tb.sv =====
`timescale 1ns / 1ps

module label_path_to_tag_entry_tb;
    import lptte_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_CHARS = 80;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    path_item_t  item;
    logic        result_valid;
    logic        result_stall;
    tag_result_t result;

    int mismatches;
    int pending;
    int paths_ok;
    int paths_failed;

    int send_idle_pct;
    int stall_pct;
    int chars_sent;
    int paths_sent;
    int quiet_cycles;

    logic [7:0] path_bytes[$];

    label_path_to_tag_entry uut (.*);

    tag_entry_checker tag_check (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Ends the run if the block stops moving in both directions.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            path_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] white_char();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    // Appends one well-formed item with a random number field; some values overflow
    // or are negative, which the block must reject.
    function automatic void put_random_field();
        logic [7:0] q;
        int         sign_kind;
        int         ndig;
        logic       zeros;
        q         = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        sign_kind = $urandom_range(3);
        zeros     = (sign_kind == 3) && $urandom_range(1);
        put_text("/label[@tag=");
        path_bytes.push_back(q);
        repeat ($urandom_range(2))
            path_bytes.push_back(white_char());
        if (sign_kind == 2)
            path_bytes.push_back(CH_PLUS);
        else if (sign_kind == 3)
            path_bytes.push_back(CH_MINUS);
        ndig = 0;
        case ($urandom_range(9))
            0:       put_text($urandom_range(1) ? "9223372036854775807" : "9223372036854775808");
            1:       ndig = $urandom_range(18, 22);
            default: ndig = $urandom_range(1, 4);
        endcase
        repeat (ndig)
            path_bytes.push_back(zeros ? CH_ZERO : CH_ZERO + 8'($urandom_range(9)));
        path_bytes.push_back(q);
        path_bytes.push_back(CH_CLOSE);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        item.in_char   <= c;
        item.is_last   <= last;
        do
            @(posedge clk);
        while (item_stall);
        chars_sent++;
    endtask

    task automatic send_path();
        for (int i = 0; i < path_bytes.size(); i++)
            send_char(path_bytes[i], i == path_bytes.size() - 1);
        paths_sent++;
    endtask

    task automatic send_text(input string s);
        path_bytes.delete();
        put_text(s);
        send_path();
    endtask

    // Mostly well-formed paths; the rest have one byte corrupted, are cut short,
    // or are plain noise.
    task automatic send_random_path();
        int kind;
        int cut;
        path_bytes.delete();
        kind = $urandom_range(9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 8))
                path_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            put_text("/document/label");
            repeat ($urandom_range(3))
                put_random_field();
            if (kind == 7)
                path_bytes[$urandom_range(path_bytes.size() - 1)] = 8'($urandom_range(255));
            if (kind == 8)
            begin
                cut = $urandom_range(1, path_bytes.size());
                while (path_bytes.size() > cut)
                    void'(path_bytes.pop_back());
            end
        end
        send_path();
    endtask

    // Holds the input back until every predicted result has been transferred.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int start;
        clk           = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_stall  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        chars_sent    = 0;
        paths_sent    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("/document/label");
        send_text("/document/label/label[@tag='9223372036854775807']/label[@tag=\"-0\"]");
        send_text("/document/label/label[@tag=\" \t\012\013\014\015+9223372036854775808\"]");
        send_text("/document/label/label[@tag=\"0\"]/label[@tag='18446744073709551615']");
        send_text("/document/label/label[@tag='-5']");
        send_text("/document/label/label[@tag='']");
        send_text("/document/label/label[@tag='12\"]");
        send_text("/document/label/label[@tag='1 2']");
        send_text("/document/label/label[@tag='+-1']");
        send_text("/document/label/label[@tag=5']");
        send_text("/document/label/labex");
        send_text("/document/label/label[@tag='7'");
        send_text("/document/label/label[@tag='7'x");
        send_text("/document/label/label[@tag=");
        send_text("/docu");
        send_text("x");
        // A zero byte in the prefix, then a byte with every bit set inside a number.
        path_bytes.delete();
        put_text("/doc");
        path_bytes.push_back(8'h00);
        put_text("ument/label");
        send_path();
        path_bytes.delete();
        put_text("/document/label/label[@tag='1");
        path_bytes.push_back(8'hff);
        put_text("']");
        send_path();
        wait_for_results();

        for (int mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            start = chars_sent;
            while (chars_sent - start < RANDOM_CHARS / 4)
                send_random_path();
            wait_for_results();
        end

        stall_pct = 0;
        repeat (8) @(posedge clk);
        $display("Sent %0d path characters in %0d paths: %0d well formed, %0d rejected,",
                 chars_sent, paths_sent, paths_ok, paths_failed);
        $display("under no idling, sender gaps, receiver stalls and both mixed.");
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== label_path_to_tag_entry.f =====
design/lptte_pkg.sv
design/label_path_to_tag_entry.sv
test/tag_entry_checker.sv
test/label_path_to_tag_entry_tb.sv
